>>> design/u8pc_pkg.sv
// ----------------------------------------------------------------------------
// u8pc_pkg
// Types and constants shared by the printable UTF-8 byte checker.
// ----------------------------------------------------------------------------
package u8pc_pkg;

  // status codes reported with every byte
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CONTROL    = 3'd1,
    ST_DEL        = 3'd2,
    ST_BAD_LEAD   = 3'd3,
    ST_BAD_CONT   = 3'd4,
    ST_INCOMPLETE = 3'd5
  } status_e;

  // byte classes
  localparam logic [7:0] FirstPrintable = 8'h20;
  localparam logic [7:0] DelByte        = 8'h7F;
  localparam logic [7:0] MinTwoLead     = 8'hC2;
  localparam logic [7:0] MaxFourLead    = 8'hF4;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [2:0] status;
    logic       verdict_final;
  } out_beat_t;

  // checker state carried from byte to byte
  typedef struct packed {
    logic [1:0] bytes_owed;
    status_e    first_error;
  } chk_state_t;

endpackage

>>> design/u8pc_step.sv
// ----------------------------------------------------------------------------
// u8pc_step
// Per-byte decision: classifies one byte against the running state and
// gives the status for this beat and the state for the next byte.
// ----------------------------------------------------------------------------
module u8pc_step (
  input  u8pc_pkg::in_beat_t   beat_i,
  input  u8pc_pkg::chk_state_t state_i,
  output u8pc_pkg::out_beat_t  result_o,
  output u8pc_pkg::chk_state_t state_o
);
  import u8pc_pkg::*;

  logic [7:0] b;
  status_e    lead_st;
  logic [1:0] lead_owed;
  status_e    err;
  logic [1:0] owed;

  assign b = beat_i.data_byte;

  // classification of a byte seen outside a sequence
  always_comb begin
    lead_owed = 2'd0;
    if (b < FirstPrintable) begin
      lead_st = ST_CONTROL;
    end else if (b == DelByte) begin
      lead_st = ST_DEL;
    end else if (!b[7]) begin
      lead_st = ST_OK;
    end else if (b[7:5] == 3'b110 && b >= MinTwoLead) begin
      lead_st   = ST_OK;
      lead_owed = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      lead_st   = ST_OK;
      lead_owed = 2'd2;
    end else if (b[7:3] == 5'b11110 && b <= MaxFourLead) begin
      lead_st   = ST_OK;
      lead_owed = 2'd3;
    end else begin
      lead_st = ST_BAD_LEAD;
    end
  end

  // running status; once an error is held the rest of the string is ignored
  always_comb begin
    err  = state_i.first_error;
    owed = state_i.bytes_owed;
    if (state_i.first_error == ST_OK) begin
      if (state_i.bytes_owed != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          err = ST_BAD_CONT;
        end else begin
          owed = state_i.bytes_owed - 2'd1;
        end
      end else begin
        err  = lead_st;
        owed = lead_owed;
      end
      if (beat_i.end_of_string && err == ST_OK && owed != 2'd0) begin
        err = ST_INCOMPLETE;
      end
    end
  end

  // result and next state; the end of a string clears everything
  always_comb begin
    result_o.status        = err;
    result_o.verdict_final = beat_i.end_of_string;
    if (beat_i.end_of_string) begin
      state_o.bytes_owed  = 2'd0;
      state_o.first_error = ST_OK;
    end else begin
      state_o.bytes_owed  = owed;
      state_o.first_error = err;
    end
  end

endmodule

>>> design/utf8_printable_byte_checker.sv
// ----------------------------------------------------------------------------
// utf8_printable_byte_checker
// Checks strings for printable, well-formed UTF-8, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one byte of a string per beat, with
//   end_of_string set on its last byte. The output channel returns one
//   beat per input byte: the running status (first error of the string so
//   far, or ok) and verdict_final, set when the beat closes the string.
//   A byte taken from the input channel sits in the input register, is
//   checked and lands in the result register, and is presented from there.
//   Throughput is one byte per cycle while the receiver does not stall; the
//   only loop is the two-bit owed count and the held error code, updated in
//   the same cycle the byte moves into the result register.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more byte, and only then is in_stall_o raised.
//   Reset clears both valid flags and the checker state (no bytes owed,
//   no error), so the first byte after reset starts a fresh string.
// ----------------------------------------------------------------------------
module utf8_printable_byte_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  u8pc_pkg::in_beat_t   in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output u8pc_pkg::out_beat_t  out_beat_o
);
  import u8pc_pkg::*;

  logic       in_vld_q;
  in_beat_t   in_q;
  logic       out_vld_q;
  out_beat_t  out_q;
  chk_state_t state_q;
  chk_state_t state_d;
  out_beat_t  result_d;
  logic       advance;
  logic       accept;

  // handshake: the input register moves on when the result register is free
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // per-byte check
  u8pc_step u_step (
    .beat_i   (in_q),
    .state_i  (state_q),
    .result_o (result_d),
    .state_o  (state_d)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q              <= 1'b0;
      out_vld_q             <= 1'b0;
      state_q.bytes_owed    <= 2'd0;
      state_q.first_error   <= ST_OK;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_beat_i;
    end
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

endmodule
